@@ rtl/mts_pkg.sv @@
// Shared types and constants of the message timing statistics table.
package mts_pkg;

   localparam int DATA_W     = 32;
   localparam int SAMPLE_W   = 9;
   localparam int LIMIT_W    = 8;
   localparam int WINDOW_W   = 16;
   localparam int BYTES_W    = 16;
   localparam int RATE_NW    = 42;
   localparam int CSR_W      = 16;

   localparam logic [DATA_W-1:0]   MIN_RESET     = 32'd10000000;
   localparam logic [9:0]          MS_PER_SEC    = 10'd1000;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET   = 8'd20;
   localparam logic [WINDOW_W-1:0] WINDOW_RESET  = 16'd1000;

   localparam logic CMD_DATA  = 1'b0;
   localparam logic CMD_ERROR = 1'b1;

   localparam logic CSR_HALVING_LIMIT  = 1'b0;
   localparam logic CSR_RATE_WINDOW_MS = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic [DATA_W-1:0]   msg_cnt;
      logic [DATA_W-1:0]   err_cnt;
      logic [DATA_W-1:0]   last_stamp;
      logic [DATA_W-1:0]   last_iv;
      logic [DATA_W-1:0]   iv_sum;
      logic [SAMPLE_W-1:0] iv_samples;
      logic [DATA_W-1:0]   mean_iv;
      logic [DATA_W-1:0]   min_iv;
      logic [DATA_W-1:0]   max_iv;
      logic [DATA_W-1:0]   irreg_cnt;
      logic [DATA_W-1:0]   win_bytes;
      logic [DATA_W-1:0]   win_start;
      logic [DATA_W-1:0]   rate;
   } entry_rec_type;

   typedef struct packed {
      logic [DATA_W-1:0] msg_cnt;
      logic [DATA_W-1:0] err_cnt;
   } type_rec_type;

   localparam entry_rec_type ENTRY_RESET = '{min_iv: MIN_RESET, default: '0};

endpackage

@@ rtl/message_timing_statistics_table_top.sv @@
// Top level of the message timing statistics table.
// Keeps message and error counters per protocol type and per (type, id) entry,
// plus interval statistics and a byte rate per entry, and answers every request
// beat with one response beat holding the updated statistics. After reset a
// clearing pass writes every entry, NUM_TYPES * NUM_IDS of them (4096 at the
// defaults), with req_stall held high; CSR writes are taken throughout. An
// event then passes through the read, calc, divide and write states; the mean
// is recomputed by a 32-bit bit-serial divider and the byte rate by a 42-bit
// bit-serial divider, run in parallel with the mean. The next request is taken
// while a response waits.
module message_timing_statistics_table_top #(
   parameter int NUM_TYPES = 16,
   parameter int NUM_IDS   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [3:0]  req_ptype,
   input  logic [7:0]  req_msg_id,
   input  logic        req_id_valid,
   input  logic [15:0] req_byte_count,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_type_count,
   output logic [31:0] rsp_type_errors,
   output logic [31:0] rsp_entry_count,
   output logic [31:0] rsp_entry_errors,
   output logic [31:0] rsp_mean_interval,
   output logic [31:0] rsp_min_interval,
   output logic [31:0] rsp_max_interval,
   output logic [31:0] rsp_rate_bytes_per_sec,
   output logic [31:0] rsp_irregular_count,
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int DEPTH = NUM_TYPES * NUM_IDS;
   localparam int EAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TAW   = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
   localparam int DW    = mts_pkg::DATA_W;
   localparam int SW    = mts_pkg::SAMPLE_W;
   localparam int RNW   = mts_pkg::RATE_NW;

   mts_pkg::state_type state_ff, state_in;

   logic [mts_pkg::LIMIT_W-1:0]  limit_ff;
   logic [mts_pkg::WINDOW_W-1:0] window_ff;

   logic [EAW-1:0] clr_cnt_ff, clr_cnt_in;

   // captured request beat
   logic           cmd_ff, idv_ff, pt_ok_ff, have_ff;
   logic [15:0]    bytes_ff;
   logic [DW-1:0]  time_ff;
   logic [EAW-1:0] eaddr_ff;
   logic [TAW-1:0] taddr_ff;

   mts_pkg::entry_rec_type entry_rd, rec_ff, rec_in, final_rec, entry_wdata;
   mts_pkg::type_rec_type  type_rd, trec_ff, trec_in, type_wdata;

   logic           accept, can_write;
   logic           entry_we, type_we;
   logic [EAW-1:0] entry_waddr;
   logic [TAW-1:0] type_waddr;

   logic           mean_go, rate_go, mean_upd_ff, rate_upd_ff;
   logic           mean_busy, rate_busy;
   logic [DW-1:0]  mean_num, mean_q;
   logic [SW-1:0]  mean_den;
   logic [RNW-1:0] rate_num, rate_q;
   logic [DW-1:0]  rate_den;

   logic           rsp_valid_ff, rsp_valid_in;
   mts_pkg::type_rec_type  rsp_trec_ff;
   mts_pkg::entry_rec_type rsp_rec_ff;

   assign accept    = req_valid && !req_stall;
   assign can_write = !(rsp_valid_ff && rsp_stall);

   // ---------------- CSR ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff  <= mts_pkg::LIMIT_RESET;
         window_ff <= mts_pkg::WINDOW_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_addr)
            mts_pkg::CSR_HALVING_LIMIT:  limit_ff  <= csr_wdata[mts_pkg::LIMIT_W-1:0];
            mts_pkg::CSR_RATE_WINDOW_MS: window_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mts_pkg::ST_CLEAR: if (clr_cnt_ff == EAW'(DEPTH - 1)) state_in = mts_pkg::ST_IDLE;
         mts_pkg::ST_IDLE:  if (req_valid) state_in = mts_pkg::ST_READ;
         mts_pkg::ST_READ:  state_in = mts_pkg::ST_CALC;
         mts_pkg::ST_CALC:  state_in = mts_pkg::ST_DIV;
         mts_pkg::ST_DIV:   if (!mean_busy && !rate_busy) state_in = mts_pkg::ST_WRITE;
         mts_pkg::ST_WRITE: if (can_write) state_in = mts_pkg::ST_IDLE;
         default:           state_in = mts_pkg::ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      req_stall   = 1'b1;
      entry_we    = 1'b0;
      type_we     = 1'b0;
      entry_waddr = eaddr_ff;
      type_waddr  = taddr_ff;
      entry_wdata = final_rec;
      type_wdata  = trec_ff;
      clr_cnt_in  = clr_cnt_ff;
      unique case (state_ff)
         mts_pkg::ST_CLEAR: begin
            entry_we    = 1'b1;
            entry_waddr = clr_cnt_ff;
            entry_wdata = mts_pkg::ENTRY_RESET;
            type_we     = (32'(clr_cnt_ff) < 32'(NUM_TYPES));
            type_waddr  = TAW'(clr_cnt_ff);
            type_wdata  = '0;
            clr_cnt_in  = clr_cnt_ff + 1'b1;
         end
         mts_pkg::ST_IDLE:  req_stall = 1'b0;
         mts_pkg::ST_WRITE: begin
            entry_we = can_write && pt_ok_ff && have_ff;
            type_we  = can_write && pt_ok_ff;
         end
         default: ;
      endcase
   end

   // ---------------- update of one entry ----------------
   always_comb begin
      logic [DW-1:0] dt, sum_new, diff, w, lim, wb_new;
      logic [SW-1:0] smp_new;
      rec_in   = entry_rd;
      trec_in  = type_rd;
      mean_go  = 1'b0;
      rate_go  = 1'b0;
      dt       = time_ff - entry_rd.last_stamp;
      sum_new  = entry_rd.iv_sum + dt;
      smp_new  = entry_rd.iv_samples + 1'b1;
      diff     = (dt >= entry_rd.last_iv) ? dt - entry_rd.last_iv : entry_rd.last_iv - dt;
      w        = time_ff - entry_rd.win_start;
      lim      = (window_ff == '0) ? 32'd1 : {16'd0, window_ff};
      wb_new   = entry_rd.win_bytes + {16'd0, bytes_ff};
      mean_num = sum_new;
      mean_den = smp_new;
      rate_num = RNW'(wb_new) * RNW'(mts_pkg::MS_PER_SEC);
      rate_den = w;
      if (cmd_ff == mts_pkg::CMD_DATA) begin
         trec_in.msg_cnt = type_rd.msg_cnt + 1'b1;
         if (have_ff) begin
            rec_in.msg_cnt = entry_rd.msg_cnt + 1'b1;
            if (time_ff != '0) begin
               if (entry_rd.last_stamp != '0) begin
                  if (dt < entry_rd.min_iv) rec_in.min_iv = dt;
                  if (dt > entry_rd.max_iv) rec_in.max_iv = dt;
                  mean_go = pt_ok_ff;
                  // sum and count halve once the count passes the limit
                  if (smp_new > {1'b0, limit_ff}) begin
                     rec_in.iv_samples = smp_new >> 1;
                     rec_in.iv_sum     = sum_new >> 1;
                  end else begin
                     rec_in.iv_samples = smp_new;
                     rec_in.iv_sum     = sum_new;
                  end
                  if (entry_rd.last_iv != '0 && diff > (entry_rd.last_iv >> 1)) begin
                     rec_in.irreg_cnt = entry_rd.irreg_cnt + 1'b1;
                  end
                  rec_in.last_iv = dt;
               end
               rec_in.last_stamp = time_ff;
               if (entry_rd.win_start == '0) begin
                  rec_in.win_bytes = {16'd0, bytes_ff};
                  rec_in.win_start = time_ff;
               end else if (w >= lim) begin
                  rate_go          = pt_ok_ff;
                  rec_in.win_bytes = '0;
                  rec_in.win_start = time_ff;
               end else begin
                  rec_in.win_bytes = wb_new;
               end
            end
         end
      end else begin
         trec_in.err_cnt = type_rd.err_cnt + 1'b1;
         if (have_ff && idv_ff) rec_in.err_cnt = entry_rd.err_cnt + 1'b1;
      end
   end

   always_comb begin
      final_rec = rec_ff;
      if (mean_upd_ff) final_rec.mean_iv = mean_q;
      if (rate_upd_ff) begin
         final_rec.rate = (rate_q[RNW-1:DW] != '0) ? '1 : rate_q[DW-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == mts_pkg::ST_WRITE && can_write) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mts_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         cmd_ff   <= req_command;
         idv_ff   <= req_id_valid;
         bytes_ff <= req_byte_count;
         time_ff  <= req_time_ms;
         pt_ok_ff <= (32'(req_ptype) < 32'(NUM_TYPES));
         have_ff  <= (32'(req_msg_id) < 32'(NUM_IDS));
         eaddr_ff <= EAW'(32'(req_ptype) * 32'(NUM_IDS) + 32'(req_msg_id));
         taddr_ff <= TAW'(req_ptype);
      end
      if (state_ff == mts_pkg::ST_CALC) begin
         rec_ff      <= rec_in;
         trec_ff     <= trec_in;
         mean_upd_ff <= mean_go;
         rate_upd_ff <= rate_go;
      end
      if (state_ff == mts_pkg::ST_WRITE && can_write) begin
         rsp_trec_ff <= pt_ok_ff ? trec_ff : '0;
         rsp_rec_ff  <= (pt_ok_ff && have_ff) ? final_rec : '0;
      end
   end

   // ---------------- storage and dividers ----------------
   mts_ram #(.WIDTH($bits(mts_pkg::entry_rec_type)), .DEPTH(DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (entry_waddr),
      .wr_data (entry_wdata),
      .rd_addr (eaddr_ff),
      .rd_data (entry_rd)
   );

   mts_ram #(.WIDTH($bits(mts_pkg::type_rec_type)), .DEPTH(NUM_TYPES)) u_type_ram (
      .clock   (clock),
      .wr_en   (type_we),
      .wr_addr (type_waddr),
      .wr_data (type_wdata),
      .rd_addr (taddr_ff),
      .rd_data (type_rd)
   );

   mts_div #(.NW(DW), .DW(SW)) u_mean_div (
      .clock (clock),
      .reset (reset),
      .start (mean_go && state_ff == mts_pkg::ST_CALC),
      .num   (mean_num),
      .den   (mean_den),
      .busy  (mean_busy),
      .quo   (mean_q)
   );

   mts_div #(.NW(RNW), .DW(DW)) u_rate_div (
      .clock (clock),
      .reset (reset),
      .start (rate_go && state_ff == mts_pkg::ST_CALC),
      .num   (rate_num),
      .den   (rate_den),
      .busy  (rate_busy),
      .quo   (rate_q)
   );

   // ---------------- outputs ----------------
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_type_count         = rsp_trec_ff.msg_cnt;
   assign rsp_type_errors        = rsp_trec_ff.err_cnt;
   assign rsp_entry_count        = rsp_rec_ff.msg_cnt;
   assign rsp_entry_errors       = rsp_rec_ff.err_cnt;
   assign rsp_mean_interval      = rsp_rec_ff.mean_iv;
   assign rsp_min_interval       = rsp_rec_ff.min_iv;
   assign rsp_max_interval       = rsp_rec_ff.max_iv;
   assign rsp_rate_bytes_per_sec = rsp_rec_ff.rate;
   assign rsp_irregular_count    = rsp_rec_ff.irreg_cnt;

   // ---------------- assertions ----------------
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == mts_pkg::ST_CLEAR |-> !accept)
      else $error("request taken during clearing pass");

   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == mts_pkg::ST_CALC |-> !mean_busy && !rate_busy)
      else $error("divider started while busy");

   a_write_gives_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == mts_pkg::ST_WRITE && can_write |=> rsp_valid_ff)
      else $error("write-back without response beat");

   a_samples_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == mts_pkg::ST_WRITE && entry_we |-> entry_wdata.iv_samples <= 9'd255)
      else $error("sample count exceeds limit range");

endmodule

@@ rtl/mts_ram.sv @@
// Generic single-port-write, registered-read RAM.
module mts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mts_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
module mts_div #(
   parameter int NW = 32,
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);

   localparam int CW = (NW > 1) ? $clog2(NW) : 1;

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] acc_ff, acc_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      trial = {rem_ff, acc_ff[NW-1]};
      fits  = (trial >= {1'b0, den_ff});
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         acc_in  = num;
         den_in  = den;
      end else if (busy_ff) begin
         // shift one numerator bit into the remainder, quotient bit in at the bottom
         rem_in = fits ? DW'(trial - {1'b0, den_ff}) : trial[DW-1:0];
         acc_in = {acc_ff[NW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = acc_ff;

endmodule

@@ sim/mts_checker.sv @@
// Checker for the message timing statistics table: predicts and compares response beats.
`timescale 1ns / 1ps
module mts_checker #(
   parameter int NUM_TYPES = 16,
   parameter int NUM_IDS   = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_command,
   input  logic [3:0]  req_ptype,
   input  logic [7:0]  req_msg_id,
   input  logic        req_id_valid,
   input  logic [15:0] req_byte_count,
   input  logic [31:0] req_time_ms,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_type_count,
   input  logic [31:0] rsp_type_errors,
   input  logic [31:0] rsp_entry_count,
   input  logic [31:0] rsp_entry_errors,
   input  logic [31:0] rsp_mean_interval,
   input  logic [31:0] rsp_min_interval,
   input  logic [31:0] rsp_max_interval,
   input  logic [31:0] rsp_rate_bytes_per_sec,
   input  logic [31:0] rsp_irregular_count,
   input  logic        csr_wr_en,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata,
   output int          error_count,
   output int          pending_count
);

   localparam int NUM_ENTRIES = NUM_TYPES * NUM_IDS;

   typedef struct packed {
      logic [31:0] type_count;
      logic [31:0] type_errors;
      logic [31:0] entry_count;
      logic [31:0] entry_errors;
      logic [31:0] mean_iv;
      logic [31:0] min_iv;
      logic [31:0] max_iv;
      logic [31:0] rate;
      logic [31:0] irregular;
   } stats_beat_type;

   stats_beat_type stats_queue[$];
   logic [7:0]  halving_limit;
   logic [15:0] rate_window;
   logic [31:0] type_msg[NUM_TYPES];
   logic [31:0] type_err[NUM_TYPES];
   mts_pkg::entry_rec_type entries[NUM_ENTRIES];

   assign pending_count = stats_queue.size();

   function automatic stats_beat_type table_update(logic cmd, logic [3:0] pt, logic [7:0] id,
                                                   logic idv, logic [15:0] nbytes,
                                                   logic [31:0] t);
      stats_beat_type s;
      mts_pkg::entry_rec_type r;
      int e;
      logic [31:0] dt, prev, diff, w, lim;
      logic [63:0] q;
      s = '0;
      if (pt >= NUM_TYPES) return s;
      e = pt * NUM_IDS + id;
      if (cmd == mts_pkg::CMD_DATA) begin
         type_msg[pt]++;
      end else begin
         type_err[pt]++;
      end
      s.type_count  = type_msg[pt];
      s.type_errors = type_err[pt];
      if (id >= NUM_IDS) return s;
      r = entries[e];
      if (cmd == mts_pkg::CMD_DATA) begin
         r.msg_cnt++;
         if (t != 0) begin
            if (r.last_stamp != 0) begin
               dt = t - r.last_stamp;
               prev = r.last_iv;
               if (dt < r.min_iv) r.min_iv = dt;
               if (dt > r.max_iv) r.max_iv = dt;
               r.iv_sum = r.iv_sum + dt;
               r.iv_samples = r.iv_samples + 1;
               r.mean_iv = r.iv_sum / {23'd0, r.iv_samples};
               if (r.iv_samples > {1'b0, halving_limit}) begin
                  r.iv_samples = r.iv_samples >> 1;
                  r.iv_sum = r.iv_sum >> 1;
               end
               if (prev != 0) begin
                  diff = (dt >= prev) ? dt - prev : prev - dt;
                  if (diff > (prev >> 1)) r.irreg_cnt++;
               end
               r.last_iv = dt;
            end
            r.last_stamp = t;
            if (r.win_start == 0) begin
               r.win_bytes = {16'd0, nbytes};
               r.win_start = t;
            end else begin
               w = t - r.win_start;
               lim = (rate_window != 0) ? {16'd0, rate_window} : 32'd1;
               r.win_bytes = r.win_bytes + nbytes;
               if (w >= lim) begin
                  q = ({32'd0, r.win_bytes} * 64'd1000) / {32'd0, w};
                  r.rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
                  r.win_bytes = '0;
                  r.win_start = t;
               end
            end
         end
      end else if (idv) begin
         r.err_cnt++;
      end
      entries[e] = r;
      s.entry_count  = r.msg_cnt;
      s.entry_errors = r.err_cnt;
      s.mean_iv      = r.mean_iv;
      s.min_iv       = r.min_iv;
      s.max_iv       = r.max_iv;
      s.rate         = r.rate;
      s.irregular    = r.irreg_cnt;
      return s;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mts_checker: %s got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      stats_beat_type want;
      if (reset) begin
         halving_limit <= mts_pkg::LIMIT_RESET;
         rate_window <= mts_pkg::WINDOW_RESET;
         for (int i = 0; i < NUM_TYPES; i++) begin
            type_msg[i] = '0;
            type_err[i] = '0;
         end
         for (int i = 0; i < NUM_ENTRIES; i++) entries[i] = mts_pkg::ENTRY_RESET;
         stats_queue.delete();
         error_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_addr == mts_pkg::CSR_HALVING_LIMIT) halving_limit <= csr_wdata[7:0];
            else rate_window <= csr_wdata;
         end
         if (req_valid && !req_stall)
            stats_queue.push_back(table_update(req_command, req_ptype, req_msg_id,
                                               req_id_valid, req_byte_count, req_time_ms));
         if (rsp_valid && !rsp_stall) begin
            if (stats_queue.size() == 0) begin
               report_mismatch("unexpected beat", 0, 0);
            end else begin
               want = stats_queue.pop_front();
               if (rsp_type_count != want.type_count)
                  report_mismatch("type_count", rsp_type_count, want.type_count);
               if (rsp_type_errors != want.type_errors)
                  report_mismatch("type_errors", rsp_type_errors, want.type_errors);
               if (rsp_entry_count != want.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, want.entry_count);
               if (rsp_entry_errors != want.entry_errors)
                  report_mismatch("entry_errors", rsp_entry_errors, want.entry_errors);
               if (rsp_mean_interval != want.mean_iv)
                  report_mismatch("mean_interval", rsp_mean_interval, want.mean_iv);
               if (rsp_min_interval != want.min_iv)
                  report_mismatch("min_interval", rsp_min_interval, want.min_iv);
               if (rsp_max_interval != want.max_iv)
                  report_mismatch("max_interval", rsp_max_interval, want.max_iv);
               if (rsp_rate_bytes_per_sec != want.rate)
                  report_mismatch("rate", rsp_rate_bytes_per_sec, want.rate);
               if (rsp_irregular_count != want.irregular)
                  report_mismatch("irregular_count", rsp_irregular_count, want.irregular);
            end
         end
      end
   end

endmodule

@@ sim/message_timing_statistics_table_top_test.sv @@
// Testbench top for the message timing statistics table: stimulus and verdict.
`timescale 1ns / 1ps
module message_timing_statistics_table_top_test;

   localparam int WATCHDOG_LIMIT = 40000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = mts_pkg::CMD_DATA;
   logic [3:0]  req_ptype = '0;
   logic [7:0]  req_msg_id = '0;
   logic        req_id_valid = 1'b0;
   logic [15:0] req_byte_count = '0;
   logic [31:0] req_time_ms = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_type_count, rsp_type_errors, rsp_entry_count, rsp_entry_errors;
   logic [31:0] rsp_mean_interval, rsp_min_interval, rsp_max_interval;
   logic [31:0] rsp_rate_bytes_per_sec, rsp_irregular_count;
   logic        csr_wr_en = 1'b0;
   logic        csr_addr = mts_pkg::CSR_HALVING_LIMIT;
   logic [15:0] csr_wdata = '0;
   int          error_count, pending_count;
   int          idle_cycles = 0;
   bit          hold_rsp = 1'b0;
   bit          long_hold = 1'b0;
   logic [31:0] stamp_clock[16];

   always #4 clock = ~clock;

   message_timing_statistics_table_top u_top (.*);
   mts_checker u_check (.*);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("message_timing_statistics_table_top_test: done, errors");
         $finish;
      end
   end

   function automatic int gap_len();
      return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            long_hold = 1'b0;
         end else if (hold_rsp) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            n = gap_len();
            rsp_stall <= (n != 0);
            repeat (n == 0 ? $urandom_range(1, 20) : n) @(posedge clock);
         end
      end
   end

   task automatic csr_write(logic addr, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // stop offering and wait until every expected beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      hold_rsp = 1'b1;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      hold_rsp = 1'b0;
   endtask

   task automatic send_beat(logic cmd, logic [3:0] pt, logic [7:0] id, logic idv,
                            logic [15:0] nb, logic [31:0] t, bit gaps);
      int n;
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_ptype      <= pt;
      req_msg_id     <= id;
      req_id_valid   <= idv;
      req_byte_count <= nb;
      req_time_ms    <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n = gaps ? gap_len() : 0;
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // data beat on a hot entry with a plausible timestamp progression
   task automatic send_timed(logic [3:0] pt, logic [7:0] id, bit gaps);
      logic [31:0] step;
      case ($urandom_range(0, 3))
         0: step = $urandom_range(1, 50);
         1: step = $urandom_range(100, 300);
         2: step = $urandom_range(500, 3000);
         default: step = $urandom;
      endcase
      stamp_clock[pt] = stamp_clock[pt] + step;
      send_beat(mts_pkg::CMD_DATA, pt, id, 1'($urandom_range(0, 1)), 16'($urandom),
                stamp_clock[pt], gaps);
   endtask

   initial begin
      logic [15:0] windows[4];
      logic [7:0]  limits[4];
      for (int i = 0; i < 16; i++) stamp_clock[i] = $urandom_range(1, 1000);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, both commands, zero time, zero limit and window
      send_beat(mts_pkg::CMD_DATA, 4'd0, 8'd0, 1'b0, 16'd0, 32'd0, 0);
      send_beat(mts_pkg::CMD_DATA, 4'd15, 8'd255, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 0);
      send_beat(mts_pkg::CMD_DATA, 4'd15, 8'd255, 1'b1, 16'hFFFF, 32'd5, 0);
      send_beat(mts_pkg::CMD_DATA, 4'd15, 8'd255, 1'b1, 16'hFFFF, 32'd2000, 0);
      send_beat(mts_pkg::CMD_ERROR, 4'd15, 8'd255, 1'b1, 16'd0, 32'd0, 0);
      send_beat(mts_pkg::CMD_ERROR, 4'd15, 8'd255, 1'b0, 16'd0, 32'd0, 0);
      send_beat(mts_pkg::CMD_ERROR, 4'd3, 8'd7, 1'b0, 16'h1234, 32'd99, 0);
      for (int i = 1; i <= 5; i++)
         send_beat(mts_pkg::CMD_DATA, 4'd1, 8'd1, 1'b0, 16'hFFFF,
                   i * 32'd1000 + (i[0] ? 32'd900 : 32'd0), 0);
      drain();
      csr_write(mts_pkg::CSR_HALVING_LIMIT, 16'd0);
      csr_write(mts_pkg::CSR_RATE_WINDOW_MS, 16'd0);
      for (int i = 1; i <= 6; i++)
         send_beat(mts_pkg::CMD_DATA, 4'd2, 8'd200, 1'b0, 16'd100, i * 32'd37, 0);
      drain();
      csr_write(mts_pkg::CSR_HALVING_LIMIT, 16'd255);
      csr_write(mts_pkg::CSR_RATE_WINDOW_MS, 16'hFFFF);
      for (int i = 1; i <= 4; i++)
         send_beat(mts_pkg::CMD_DATA, 4'd2, 8'd201, 1'b0, 16'hFFFF, i * 32'd70000, 0);
      drain();

      // pressure: receiver holds off while sender keeps offering
      long_hold = 1'b1;
      fork
         for (int i = 0; i < 30; i++) send_timed(4'd5, 8'(i % 3), 0);
      join
      req_valid <= 1'b0;
      drain();

      // random phases across several settings
      limits  = '{8'd1, 8'd3, 8'd20, 8'd255};
      windows = '{16'd1, 16'd50, 16'd1000, 16'hFFFF};
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(mts_pkg::CSR_HALVING_LIMIT,
                   ph < 4 ? {8'd0, limits[ph]} : 16'($urandom_range(0, 255)));
         csr_write(mts_pkg::CSR_RATE_WINDOW_MS, ph < 4 ? windows[3 - ph] : 16'($urandom));
         for (int i = 0; i < 200; i++) begin
            if ($urandom_range(0, 9) < 8)
               send_timed(4'($urandom_range(0, 3)), 8'($urandom_range(0, 3)), 1);
            else
               send_beat(1'($urandom_range(0, 1)), 4'($urandom), 8'($urandom),
                         1'($urandom_range(0, 1)), 16'($urandom),
                         ($urandom_range(0, 3) == 0) ? 32'd0 : 32'($urandom), 1);
         end
         req_valid <= 1'b0;
         drain();
      end

      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("message_timing_statistics_table_top_test: done, clean");
      end else begin
         $display("message_timing_statistics_table_top_test: done, errors");
      end
      $finish;
   end

endmodule

@@ message_timing_statistics_table_top.f @@
rtl/mts_pkg.sv
rtl/mts_ram.sv
rtl/mts_div.sv
rtl/message_timing_statistics_table_top.sv
sim/mts_checker.sv
sim/message_timing_statistics_table_top_test.sv
